/* rtl/spr_pkg.sv */
// spr_pkg: types, constants and helpers shared by the shelf rectangle packer
// depends on nothing
package spr_pkg;

   localparam int MAX_ROWS     = 64;
   localparam int COORD_BITS   = 16;
   localparam int ROW_IDX_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DIM_BITS     = 12;
   localparam int PAD_BITS     = 6;
   localparam int MULT_BITS    = 8;
   localparam int WIDE_BITS    = COORD_BITS + 14;
   localparam int CFG_BITS     = 16;

   localparam logic [1:0] MODE_PLACE = 2'd0;
   localparam logic [1:0] MODE_BATCH = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] CSR_INIT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_INIT_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PADDING     = 2'd2;

   localparam logic [CFG_BITS-1:0]  INIT_SIZE_RESET = CFG_BITS'(256);
   localparam logic [PAD_BITS-1:0]  PADDING_RESET   = PAD_BITS'(6);
   localparam logic [MULT_BITS-1:0] MULT_MAX        = {MULT_BITS{1'b1}};

   typedef struct packed {
      logic [1:0]          mode;
      logic [DIM_BITS-1:0] rect_width;
      logic [DIM_BITS-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [15:0]          pos_x;
      logic [15:0]          pos_y;
      logic [MULT_BITS-1:0] size_multiplier;
      logic [15:0]          atlas_width_now;
      logic [15:0]          atlas_height_now;
      logic                 status;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] fill;
      logic [DIM_BITS-1:0]   tallest;
      logic                  locked;
   } row_type;

   function automatic logic [COORD_BITS-1:0] sat_coord(input logic [WIDE_BITS-1:0] v);
      logic [WIDE_BITS-1:0] lim;
      lim = WIDE_BITS'({COORD_BITS{1'b1}});
      return (v > lim) ? {COORD_BITS{1'b1}} : v[COORD_BITS-1:0];
   endfunction

   function automatic logic [COORD_BITS-1:0] init_size(input logic [CFG_BITS-1:0] v);
      logic [CFG_BITS-1:0] nz;
      nz = (v == '0) ? CFG_BITS'(1) : v;
      return sat_coord(WIDE_BITS'(nz));
   endfunction

endpackage

/* rtl/spr_cell.sv */
// spr_cell: one shelf row of the rotating row chain
// depends on spr_pkg
module spr_cell import spr_pkg::*; (
   input  logic    clock,
   input  logic    clear,
   input  logic    shift,
   input  row_type row_in,
   output row_type row_out
);

   row_type row_ff;

   always_ff @(posedge clock) begin
      if (clear) begin
         row_ff <= '0;
      end else if (shift) begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

/* rtl/shelf_rectangle_packer.sv */
// shelf_rectangle_packer: shelf atlas packer, row chain plus scan controller
// depends on spr_pkg and spr_cell
// placement: start, ST_PREP, then a scan over all MAX_ROWS rows before rsp_valid; other modes answer from ST_PREP
// throughput: one item at a time; a placement holds the block for the full rotation of the MAX_ROWS row chain
// rsp_valid is a one-cycle strobe; the receiver cannot stall
// reset: shelves empty, atlas 256 x 256, padding 6, multiplier 1
module shelf_rectangle_packer import spr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [CFG_BITS-1:0] csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_SCAN} state_type;

   state_type                state_ff;
   req_type                  req_ff;
   logic [CFG_BITS-1:0]      init_w_ff, init_h_ff;
   logic [PAD_BITS-1:0]      pad_ff;
   logic [COORD_BITS-1:0]    atlas_w_ff, atlas_h_ff;
   logic [MULT_BITS-1:0]     mult_ff, mult_in;
   logic [COORD_BITS+MULT_BITS-1:0] eff_w_ff, eff_h_ff;
   logic [COORD_BITS-1:0]    y_ff, px_ff, py_ff;
   logic                     found_ff;
   logic [ROW_IDX_BITS-1:0]  idx_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   row_type                  rows [MAX_ROWS];
   row_type                  head, tail;
   logic                     cells_clear, shift;

   logic [WIDE_BITS-1:0]     need_w, y_skip, y_bottom;
   logic                     too_wide, too_short, place_now;
   logic [COORD_BITS-1:0]    px_now;
   logic [COORD_BITS-1:0]    batch_w, batch_h;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign shift       = (state_ff == ST_SCAN);
   assign cells_clear = reset || (state_ff == ST_PREP && req_ff.mode == MODE_CLEAR);

   // atlas sizes scaled by the batch multiplier at batch end
   assign batch_w = sat_coord(WIDE_BITS'(atlas_w_ff) * WIDE_BITS'(mult_ff));
   assign batch_h = sat_coord(WIDE_BITS'(atlas_h_ff) * WIDE_BITS'(mult_ff));

   // ring: each row moves one place toward the head every scan cycle
   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
      row_type nxt;
      if (i == MAX_ROWS - 1) begin : g_tail
         assign nxt = tail;
      end else begin : g_mid
         assign nxt = rows[i+1];
      end
      spr_cell u_cell (
         .clock   (clock),
         .clear   (cells_clear),
         .shift   (shift),
         .row_in  (nxt),
         .row_out (rows[i])
      );
   end

   assign head = rows[0];

   always_comb begin
      need_w    = WIDE_BITS'(head.fill) + WIDE_BITS'(req_ff.rect_width)
                  + WIDE_BITS'(pad_ff);
      y_skip    = WIDE_BITS'(y_ff) + WIDE_BITS'(head.tallest) + WIDE_BITS'(pad_ff);
      y_bottom  = WIDE_BITS'(y_ff) + WIDE_BITS'(req_ff.rect_height);
      too_wide  = need_w > WIDE_BITS'(eff_w_ff);
      too_short = head.locked && (req_ff.rect_height > head.tallest);
      place_now = !found_ff && !too_wide && !too_short;
      px_now    = sat_coord(WIDE_BITS'(head.fill) + WIDE_BITS'(pad_ff));
      tail      = head;
      mult_in   = mult_ff;
      if (!found_ff) begin
         if (too_wide) begin
            tail.locked = 1'b1;
         end else if (place_now) begin
            tail.fill = sat_coord(need_w);
            if (req_ff.rect_height > head.tallest) begin
               tail.tallest = req_ff.rect_height;
            end
            // bottom overflow grows the next batch
            if (y_bottom > WIDE_BITS'(eff_h_ff) && mult_ff != MULT_MAX) begin
               mult_in = mult_ff + MULT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_w_ff    <= INIT_SIZE_RESET;
         init_h_ff    <= INIT_SIZE_RESET;
         pad_ff       <= PADDING_RESET;
         atlas_w_ff   <= init_size(INIT_SIZE_RESET);
         atlas_h_ff   <= init_size(INIT_SIZE_RESET);
         mult_ff      <= MULT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_PREP && req_ff.mode != MODE_PLACE)
                         || (state_ff == ST_SCAN && idx_ff == ROW_IDX_BITS'(MAX_ROWS - 1));
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INIT_WIDTH:  init_w_ff <= csr_data;
               CSR_INIT_HEIGHT: init_h_ff <= csr_data;
               CSR_PADDING:     pad_ff    <= csr_data[PAD_BITS-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               eff_w_ff <= atlas_w_ff * mult_ff;
               eff_h_ff <= atlas_h_ff * mult_ff;
               y_ff     <= COORD_BITS'(pad_ff);
               found_ff <= 1'b0;
               idx_ff   <= '0;
               rsp_ff.pos_x  <= '0;
               rsp_ff.pos_y  <= '0;
               rsp_ff.status <= 1'b0;
               if (req_ff.mode == MODE_PLACE) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_IDLE;
                  if (req_ff.mode == MODE_BATCH) begin
                     mult_ff <= MULT_BITS'(1);
                     rsp_ff.size_multiplier <= MULT_BITS'(1);
                     if (mult_ff > MULT_BITS'(1)) begin
                        atlas_w_ff <= batch_w;
                        atlas_h_ff <= batch_h;
                        rsp_ff.atlas_width_now  <= 16'(batch_w);
                        rsp_ff.atlas_height_now <= 16'(batch_h);
                     end else begin
                        rsp_ff.atlas_width_now  <= 16'(atlas_w_ff);
                        rsp_ff.atlas_height_now <= 16'(atlas_h_ff);
                     end
                  end else if (req_ff.mode == MODE_CLEAR) begin
                     mult_ff    <= MULT_BITS'(1);
                     atlas_w_ff <= init_size(init_w_ff);
                     atlas_h_ff <= init_size(init_h_ff);
                     rsp_ff.size_multiplier  <= MULT_BITS'(1);
                     rsp_ff.atlas_width_now  <= 16'(init_size(init_w_ff));
                     rsp_ff.atlas_height_now <= 16'(init_size(init_h_ff));
                  end else begin
                     rsp_ff.size_multiplier  <= mult_ff;
                     rsp_ff.atlas_width_now  <= 16'(atlas_w_ff);
                     rsp_ff.atlas_height_now <= 16'(atlas_h_ff);
                  end
               end
            end
            ST_SCAN: begin
               idx_ff  <= idx_ff + ROW_IDX_BITS'(1);
               mult_ff <= mult_in;
               if (place_now) begin
                  found_ff <= 1'b1;
                  px_ff    <= px_now;
                  py_ff    <= y_ff;
               end else if (!found_ff) begin
                  y_ff <= sat_coord(y_skip);
               end
               if (idx_ff == ROW_IDX_BITS'(MAX_ROWS - 1)) begin
                  state_ff     <= ST_IDLE;
                  rsp_ff.size_multiplier  <= mult_in;
                  rsp_ff.atlas_width_now  <= 16'(atlas_w_ff);
                  rsp_ff.atlas_height_now <= 16'(atlas_h_ff);
                  rsp_ff.status <= !(found_ff || place_now);
                  rsp_ff.pos_x  <= place_now ? 16'(px_now) :
                                   (found_ff ? 16'(px_ff) : 16'd0);
                  rsp_ff.pos_y  <= place_now ? 16'(y_ff) :
                                   (found_ff ? 16'(py_ff) : 16'd0);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.pos_x == '0 && rsp_data.pos_y == '0))
      else $error("failed placement reports a position");
   a_mult_nonzero: assert property (@(posedge clock) disable iff (reset)
      mult_ff != '0)
      else $error("batch multiplier reached zero");

endmodule

/* tb/sv/shelf_rectangle_packer_checker.sv */
// shelf_rectangle_packer_checker: watches the request, response and csr transfers,
// predicts each response from its own shelf model and compares; depends on spr_pkg
`timescale 1ns / 100ps
module shelf_rectangle_packer_checker import spr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          busy,
   input  req_type       req_data,
   input  logic          rsp_valid,
   input  rsp_type       rsp_data,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [CFG_BITS-1:0] csr_data,
   output int            fail_count,
   output int            pending_count
);

   localparam longint COORD_LIM = (64'd1 << COORD_BITS) - 1;

   longint shelf_fill[MAX_ROWS];
   longint shelf_tall[MAX_ROWS];
   bit     shelf_lock[MAX_ROWS];
   longint atlas_w, atlas_h, mult;
   longint init_w, init_h, pad;
   rsp_type placements_due[$];

   function automatic longint clip(input longint v);
      return (v > COORD_LIM) ? COORD_LIM : v;
   endfunction

   function automatic void empty_shelves();
      for (int i = 0; i < MAX_ROWS; i++) begin
         shelf_fill[i] = 0;
         shelf_tall[i] = 0;
         shelf_lock[i] = 0;
      end
      atlas_w = clip((init_w == 0) ? 1 : init_w);
      atlas_h = clip((init_h == 0) ? 1 : init_h);
      mult = 1;
   endfunction

   function automatic rsp_type predict_packing(input req_type r);
      rsp_type o;
      longint y, ew, eh, w, h;
      bit placed;
      o = '0;
      w = longint'(r.rect_width);
      h = longint'(r.rect_height);
      placed = 0;
      if (r.mode == MODE_PLACE) begin
         y = pad;
         ew = atlas_w * mult;
         eh = atlas_h * mult;
         for (int i = 0; i < MAX_ROWS && !placed; i++) begin
            if (shelf_fill[i] + w + pad > ew) begin
               shelf_lock[i] = 1;
               y = clip(y + shelf_tall[i] + pad);
            end else if (shelf_lock[i] && h > shelf_tall[i]) begin
               y = clip(y + shelf_tall[i] + pad);
            end else begin
               if (y + h > eh && mult < 255) mult++;
               o.pos_x = 16'(clip(shelf_fill[i] + pad));
               o.pos_y = 16'(y);
               shelf_fill[i] = clip(shelf_fill[i] + w + pad);
               if (h > shelf_tall[i]) shelf_tall[i] = h;
               placed = 1;
            end
         end
         o.status = !placed;
      end else if (r.mode == MODE_BATCH) begin
         if (mult > 1) begin
            atlas_w = clip(atlas_w * mult);
            atlas_h = clip(atlas_h * mult);
         end
         mult = 1;
      end else if (r.mode == MODE_CLEAR) begin
         empty_shelves();
      end
      o.size_multiplier = MULT_BITS'(mult);
      o.atlas_width_now = 16'(atlas_w);
      o.atlas_height_now = 16'(atlas_h);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         init_w = longint'(INIT_SIZE_RESET);
         init_h = longint'(INIT_SIZE_RESET);
         pad = longint'(PADDING_RESET);
         empty_shelves();
         placements_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (placements_due.size() == 0) begin
               $error("response with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = placements_due.pop_front();
               if (want != rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (want.pos_x != rsp_data.pos_x)
                     $error("pos_x exp %0d got %0d", want.pos_x, rsp_data.pos_x);
                  if (want.pos_y != rsp_data.pos_y)
                     $error("pos_y exp %0d got %0d", want.pos_y, rsp_data.pos_y);
                  if (want.size_multiplier != rsp_data.size_multiplier)
                     $error("size_multiplier exp %0d got %0d",
                            want.size_multiplier, rsp_data.size_multiplier);
                  if (want.atlas_width_now != rsp_data.atlas_width_now)
                     $error("atlas_width_now exp %0d got %0d",
                            want.atlas_width_now, rsp_data.atlas_width_now);
                  if (want.atlas_height_now != rsp_data.atlas_height_now)
                     $error("atlas_height_now exp %0d got %0d",
                            want.atlas_height_now, rsp_data.atlas_height_now);
                  if (want.status != rsp_data.status)
                     $error("status exp %0d got %0d", want.status, rsp_data.status);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INIT_WIDTH: init_w = longint'(csr_data);
               CSR_INIT_HEIGHT: init_h = longint'(csr_data);
               CSR_PADDING: pad = longint'(csr_data[PAD_BITS-1:0]);
               default: ;
            endcase
         end
         if (start && !busy) placements_due = {placements_due, predict_packing(req_data)};
      end
      pending_count <= placements_due.size();
   end

endmodule

/* tb/sv/tb_shelf_rectangle_packer.sv */
// tb_shelf_rectangle_packer: stimulus and verdict for the shelf rectangle packer
// depends on spr_pkg, shelf_rectangle_packer and shelf_rectangle_packer_checker
`timescale 1ns / 100ps
module tb_shelf_rectangle_packer;
   import spr_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_INIT_WIDTH;
   logic [CFG_BITS-1:0] csr_data = '0;
   int fail_count, pending_count;
   int gap_odds = 6;

   shelf_rectangle_packer uut (.*);
   shelf_rectangle_packer_checker watcher (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // one request transfer, optional idle burst first
   task automatic send_item(input logic [1:0] m, input int w, input int h);
      if (gap_odds > 0 && $urandom_range(gap_odds - 1) == 0)
         repeat ($urandom_range(19, 1)) @(posedge clock);
      start <= 1;
      req_data <= '{mode: m, rect_width: w[DIM_BITS-1:0], rect_height: h[DIM_BITS-1:0]};
      do @(posedge clock); while (busy);
      start <= 0;
      // block is busy in the cycle after a transfer anyway
      @(posedge clock);
   endtask

   task automatic drain();
      do @(posedge clock); while (pending_count != 0 || busy);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85)
         send_item(MODE_PLACE, ($urandom_range(3) == 0) ? $urandom_range(4095)
                   : $urandom_range(80), ($urandom_range(3) == 0) ? $urandom_range(4095)
                   : $urandom_range(60));
      else if (pick < 93) send_item(MODE_BATCH, $urandom, $urandom);
      else if (pick < 98) send_item(MODE_CLEAR, $urandom, $urandom);
      else send_item(2'd3, $urandom, $urandom);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: field extremes and every mode
      send_item(MODE_PLACE, 0, 0);
      send_item(MODE_PLACE, 4095, 4095);
      send_item(MODE_PLACE, 100, 300);
      send_item(MODE_PLACE, 240, 10);
      send_item(MODE_PLACE, 50, 4095);
      send_item(MODE_BATCH, 0, 0);
      send_item(MODE_BATCH, 4095, 4095);
      send_item(2'd3, 4095, 0);
      send_item(MODE_CLEAR, 0, 4095);
      // sender waits for every expected result
      drain();
      write_reg(CSR_INIT_WIDTH, 0);
      write_reg(CSR_INIT_HEIGHT, 0);
      write_reg(CSR_PADDING, 0);
      send_item(MODE_CLEAR, 0, 0);
      send_item(MODE_PLACE, 1, 1);
      send_item(MODE_PLACE, 0, 0);
      send_item(MODE_PLACE, 2, 2);
      drain();
      write_reg(CSR_INIT_WIDTH, 65535);
      write_reg(CSR_INIT_HEIGHT, 65535);
      write_reg(CSR_PADDING, 63);
      send_item(MODE_CLEAR, 0, 0);
      send_item(MODE_PLACE, 4095, 4095);
      send_item(MODE_BATCH, 0, 0);
      // random phases over several register settings
      for (int p = 0; p < 5; p++) begin
         drain();
         write_reg(CSR_INIT_WIDTH, $urandom_range(1000, 1));
         write_reg(CSR_INIT_HEIGHT, (p == 2) ? 65535 : $urandom_range(600, 1));
         write_reg(CSR_PADDING, $urandom_range(63));
         send_item(MODE_CLEAR, 0, 0);
         if (p == 4) gap_odds = 0;
         for (int k = 0; k < 165; k++) random_item();
      end
      drain();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
